### rtl/video_frame_rtp_packetizer_macros.svh
// assertion macros used by the port-level checker file
`ifndef VIDEO_FRAME_RTP_PACKETIZER_MACROS_SVH
`define VIDEO_FRAME_RTP_PACKETIZER_MACROS_SVH

// property checked on every rising edge outside reset
`define VFRP_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
		else $error("vfrp assertion failed");

// property checked on every rising edge, reset included
`define VFRP_ASSERT_ALWAYS(lbl, ck, prop) \
	lbl: assert property (@(posedge ck) prop) \
		else $error("vfrp assertion failed");

`endif

### rtl/vfrp_pkg.sv
// shared types and constants of the video frame packetizer
package vfrp_pkg;

	localparam int HEADER_BYTES = 30;
	localparam int HDR_W        = HEADER_BYTES * 8;
	localparam int HCNT_W       = $clog2(HEADER_BYTES + 1);
	localparam int FRAME_W      = 21;
	localparam int SEG_W        = 10;

	localparam logic [FRAME_W-1:0] MAX_FRAME_BYTES = 21'd1048576;
	localparam logic [SEG_W-1:0]   SEGMENT_CAP     = 10'd950;
	localparam logic [31:0]        MAGIC_WORD      = 32'h30316364;
	localparam logic [7:0]         VERSION_BYTE    = 8'h81;

	localparam logic [1:0] KIND_FIRST  = 2'd1;
	localparam logic [1:0] KIND_LAST   = 2'd2;
	localparam logic [1:0] KIND_MIDDLE = 2'd3;

	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

	typedef enum logic [1:0] {
		REG_SIM_BCD,
		REG_CHANNEL,
		REG_PAYLOAD_TYPE,
		REG_MAX_SEGMENT
	} reg_index_t;

	localparam logic [47:0] SIM_RESET     = 48'h012345678901;
	localparam logic [7:0]  CHAN_RESET    = 8'd1;
	localparam logic [6:0]  PTYPE_RESET   = 7'd98;
	localparam logic [9:0]  MAXSEG_RESET  = 10'd950;

	typedef struct packed {
		logic [47:0]      sim_bcd;
		logic [7:0]       logical_channel;
		logic [6:0]       payload_type;
		logic [SEG_W-1:0] max_segment;
	} cfg_t;

	// one classified input byte, with its header fields when it opens a packet
	typedef struct packed {
		logic [7:0]       data;
		logic             pend;
		logic             open;
		logic             last;
		logic [6:0]       ptype;
		logic [15:0]      seq;
		logic [47:0]      sim;
		logic [7:0]       chan;
		logic             dtype;
		logic [1:0]       kind;
		logic [63:0]      ftime;
		logic [15:0]      igap;
		logic [15:0]      fgap;
		logic [SEG_W-1:0] seg;
	} cmd_t;

endpackage

### rtl/vfrp_cmdq.sv
// small command queue between the classifier and the byte emitter
module vfrp_cmdq import vfrp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_cmd,
	output logic full,
	input  logic rd_en,
	output cmd_t rd_cmd,
	output logic empty
);

	cmd_t               mem_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] wr_ptr_q;
	logic [CMDQ_AW-1:0] rd_ptr_q;
	logic [CMDQ_CW-1:0] count_q;
	logic               do_wr;
	logic               do_rd;

	assign full   = (count_q == CMDQ_CW'(CMDQ_DEPTH));
	assign empty  = (count_q == '0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/vfrp_front.sv
// input side: frame bookkeeping and classification of each byte
module vfrp_front import vfrp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         data_byte,
	input  logic               frame_start,
	input  logic [FRAME_W-1:0] frame_bytes,
	input  logic               is_idr,
	input  logic [63:0]        frame_time_ms,
	input  logic               q_full,
	output logic               q_push,
	output cmd_t               q_cmd
);

	logic [15:0]        seq_q;
	logic [FRAME_W-1:0] fbl_q;
	logic [SEG_W-1:0]   sbl_q;
	logic               first_q;
	logic [63:0]        cur_q;
	logic [15:0]        prev16_q;
	logic [15:0]        idr16_q;
	logic               seen_q;
	logic               idr_seen_q;
	logic               cur_idr_q;

	logic               accept;
	logic [FRAME_W-1:0] fb_clamp;
	logic [SEG_W-1:0]   lim;
	logic [FRAME_W-1:0] fbl;
	logic [SEG_W-1:0]   sbl;
	logic               first;
	logic [63:0]        cur;
	logic [15:0]        prev16;
	logic [15:0]        idr16;
	logic               idr_seen;
	logic               cur_idr;
	logic               active;
	logic               open;
	logic [SEG_W-1:0]   seg;
	logic               last;
	logic [SEG_W-1:0]   sbl_next;
	logic [FRAME_W-1:0] fbl_next;

	assign accept = push && !q_full;
	assign full   = q_full;

	always_comb begin
		if (frame_bytes == '0) begin
			fb_clamp = FRAME_W'(1);
		end else if (frame_bytes > MAX_FRAME_BYTES) begin
			fb_clamp = MAX_FRAME_BYTES;
		end else begin
			fb_clamp = frame_bytes;
		end
		if (cfg.max_segment == '0) begin
			lim = SEG_W'(1);
		end else if (cfg.max_segment > SEGMENT_CAP) begin
			lim = SEGMENT_CAP;
		end else begin
			lim = cfg.max_segment;
		end
	end

	// a new frame drops whatever was left of the old one
	assign fbl      = frame_start ? fb_clamp : fbl_q;
	assign sbl      = frame_start ? '0 : sbl_q;
	assign first    = frame_start ? 1'b1 : first_q;
	assign cur      = frame_start ? frame_time_ms : cur_q;
	assign prev16   = frame_start ? (seen_q ? cur_q[15:0] : frame_time_ms[15:0]) : prev16_q;
	assign idr16    = (frame_start && is_idr) ? frame_time_ms[15:0] : idr16_q;
	assign idr_seen = frame_start ? (idr_seen_q || is_idr) : idr_seen_q;
	assign cur_idr  = frame_start ? is_idr : cur_idr_q;

	assign active   = (fbl != '0);
	assign open     = (sbl == '0);
	assign last     = (fbl <= FRAME_W'(lim));
	assign seg      = last ? fbl[SEG_W-1:0] : lim;
	assign sbl_next = (open ? seg : sbl) - 1'b1;
	assign fbl_next = fbl - 1'b1;

	assign q_push = accept && active;

	always_comb begin
		q_cmd       = '0;
		q_cmd.data  = data_byte;
		q_cmd.pend  = (sbl_next == '0);
		q_cmd.open  = open;
		q_cmd.last  = last;
		q_cmd.ptype = cfg.payload_type;
		q_cmd.seq   = seq_q;
		q_cmd.sim   = cfg.sim_bcd;
		q_cmd.chan  = cfg.logical_channel;
		q_cmd.dtype = !cur_idr;
		q_cmd.kind  = first ? KIND_FIRST : (last ? KIND_LAST : KIND_MIDDLE);
		q_cmd.ftime = cur;
		q_cmd.igap  = idr_seen ? (cur[15:0] - idr16) : '0;
		q_cmd.fgap  = cur[15:0] - prev16;
		q_cmd.seg   = seg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q      <= '0;
			fbl_q      <= '0;
			sbl_q      <= '0;
			first_q    <= 1'b1;
			cur_q      <= '0;
			prev16_q   <= '0;
			idr16_q    <= '0;
			seen_q     <= 1'b0;
			idr_seen_q <= 1'b0;
			cur_idr_q  <= 1'b0;
		end else if (accept) begin
			cur_q      <= cur;
			prev16_q   <= prev16;
			idr16_q    <= idr16;
			seen_q     <= seen_q || frame_start;
			idr_seen_q <= idr_seen;
			cur_idr_q  <= cur_idr;
			if (active) begin
				fbl_q <= fbl_next;
				sbl_q <= sbl_next;
				if (open) begin
					seq_q   <= seq_q + 1'b1;
					first_q <= 1'b0;
				end else begin
					first_q <= first;
				end
			end else begin
				fbl_q   <= fbl;
				sbl_q   <= sbl;
				first_q <= first;
			end
		end
	end

endmodule

### rtl/vfrp_back.sv
// output side: header serialiser and result register
module vfrp_back import vfrp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  cmd_t       q_cmd,
	output logic       q_pop,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] out_byte,
	output logic       packet_end,
	output logic       run_end
);

	logic              cur_valid_q;
	logic [HCNT_W-1:0] hdr_left_q;
	logic [HDR_W-1:0]  hdr_q;
	logic [7:0]        data_q;
	logic              pend_q;
	logic              ovalid_q;
	logic [7:0]        obyte_q;
	logic              opend_q;
	logic              orun_q;

	logic              pop_fire;
	logic              produce;
	logic              is_pay;
	logic              take;
	logic [HDR_W-1:0]  hdr_new;

	assign pop_fire = pop && ovalid_q;
	assign produce  = cur_valid_q && (!ovalid_q || pop_fire);
	assign is_pay   = (hdr_left_q == '0);
	assign take     = !q_empty && (!cur_valid_q || (produce && is_pay));
	assign q_pop    = take;

	assign hdr_new = {MAGIC_WORD, VERSION_BYTE, q_cmd.last, q_cmd.ptype, q_cmd.seq,
		q_cmd.sim, q_cmd.chan, 3'b000, q_cmd.dtype, 2'b00, q_cmd.kind,
		q_cmd.ftime, q_cmd.igap, q_cmd.fgap, 6'd0, q_cmd.seg};

	assign empty      = !ovalid_q;
	assign out_byte   = obyte_q;
	assign packet_end = opend_q;
	assign run_end    = orun_q;

	always_ff @(posedge clk) begin
		if (take) begin
			hdr_q  <= hdr_new;
			data_q <= q_cmd.data;
			pend_q <= q_cmd.pend;
		end else if (produce && !is_pay) begin
			hdr_q <= {hdr_q[HDR_W-9:0], 8'h00};
		end
		if (produce) begin
			obyte_q <= is_pay ? data_q : hdr_q[HDR_W-1 -: 8];
			opend_q <= is_pay && pend_q;
			orun_q  <= is_pay;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			hdr_left_q  <= '0;
			ovalid_q    <= 1'b0;
		end else begin
			if (take) begin
				cur_valid_q <= 1'b1;
				hdr_left_q  <= q_cmd.open ? HCNT_W'(HEADER_BYTES) : '0;
			end else if (produce && is_pay) begin
				cur_valid_q <= 1'b0;
			end else if (produce) begin
				hdr_left_q <= hdr_left_q - 1'b1;
			end
			if (produce) begin
				ovalid_q <= 1'b1;
			end else if (pop_fire) begin
				ovalid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/video_frame_rtp_packetizer.sv
// top level of the video frame packetizer: config registers and the two halves
//
// channel   direction  handshake              payload
// input     in         push / full            data_byte frame_start frame_bytes is_idr frame_time_ms
// result    out        empty / pop            out_byte packet_end run_end
// config    in         cfg_wr_en (no wait)    cfg_index cfg_data
//
// one input item is taken per cycle while the command queue has room
// a byte that opens a packet gives 31 result items (30 header bytes, then the byte),
// so it keeps the emitter busy until all of them are produced; every other byte gives one item
// the emitter's single byte-wide result register sets the output rate of one item a cycle while results are taken
// reset is asynchronous and clears all control state at once; no clearing pass
// either side may stall: the 4-deep command queue and the result register decouple them
module video_frame_rtp_packetizer import vfrp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         data_byte,
	input  logic               frame_start,
	input  logic [FRAME_W-1:0] frame_bytes,
	input  logic               is_idr,
	input  logic [63:0]        frame_time_ms,
	output logic               empty,
	input  logic               pop,
	output logic [7:0]         out_byte,
	output logic               packet_end,
	output logic               run_end,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [47:0]        cfg_data
);

	cfg_t cfg_q;
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	cmd_t q_wr_cmd;
	cmd_t q_rd_cmd;

	// register file; the user must write it only while the block is idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sim_bcd         <= SIM_RESET;
			cfg_q.logical_channel <= CHAN_RESET;
			cfg_q.payload_type    <= PTYPE_RESET;
			cfg_q.max_segment     <= MAXSEG_RESET;
		end else if (cfg_wr_en) begin
			case (reg_index_t'(cfg_index))
				REG_SIM_BCD:      cfg_q.sim_bcd         <= cfg_data;
				REG_CHANNEL:      cfg_q.logical_channel <= cfg_data[7:0];
				REG_PAYLOAD_TYPE: cfg_q.payload_type    <= cfg_data[6:0];
				REG_MAX_SEGMENT:  cfg_q.max_segment     <= cfg_data[SEG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// front: frame state, segment cutting, header field capture
	vfrp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.push          (push),
		.full          (full),
		.data_byte     (data_byte),
		.frame_start   (frame_start),
		.frame_bytes   (frame_bytes),
		.is_idr        (is_idr),
		.frame_time_ms (frame_time_ms),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_cmd         (q_wr_cmd)
	);

	// classified items waiting for the emitter
	vfrp_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_cmd (q_wr_cmd),
		.full   (q_full),
		.rd_en  (q_pop),
		.rd_cmd (q_rd_cmd),
		.empty  (q_empty)
	);

	// back: header bytes when a packet opens, then the payload byte, one per cycle while results are taken
	vfrp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_cmd      (q_rd_cmd),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.out_byte   (out_byte),
		.packet_end (packet_end),
		.run_end    (run_end)
	);

endmodule

### rtl/vfrp_checker.sv
// port-level checks of the packetizer and their bind
`include "video_frame_rtp_packetizer_macros.svh"

module vfrp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_byte,
	input logic       packet_end,
	input logic       run_end
);

	logic [9:0] res_word;

	assign res_word = {out_byte, packet_end, run_end};

	// a packet only ends on a payload byte, which always closes its run
	`VFRP_ASSERT(a_pend_on_payload, clk, arst_n, (!empty && packet_end) |-> run_end)

	// a waiting result holds until taken
	`VFRP_ASSERT(a_hold, clk, arst_n, (!empty && !pop) |=> (!empty && $stable(res_word)))

	// results only leave through pop
	`VFRP_ASSERT(a_drain, clk, arst_n, $rose(empty) |-> $past(pop))

	// nothing is offered while in reset
	`VFRP_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> (empty && !full))

endmodule

bind video_frame_rtp_packetizer vfrp_checker u_vfrp_checker (.*);

### test/packet_stream_checker.sv
// checker of the packet stream: predicts every output byte of the packetizer and compares
module packet_stream_checker import vfrp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic [7:0]         data_byte,
	input  logic               frame_start,
	input  logic [FRAME_W-1:0] frame_bytes,
	input  logic               is_idr,
	input  logic [63:0]        frame_time_ms,
	input  logic               empty,
	input  logic               pop,
	input  logic [7:0]         out_byte,
	input  logic               packet_end,
	input  logic               run_end,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [47:0]        cfg_data,
	output int                 failures,
	output int                 outstanding
);

	typedef struct packed {
		logic [7:0] value;
		logic       packet_last;
		logic       item_last;
	} stream_byte_t;

	cfg_t               cfg;
	logic [15:0]        seq_num;
	logic [FRAME_W-1:0] frame_left;
	logic [SEG_W-1:0]   seg_left;
	logic [10:0]        seg_count;
	logic [63:0]        cur_time;
	logic [63:0]        prev_time;
	logic [63:0]        idr_time;
	logic               seen_frame;
	logic               seen_idr;
	logic               frame_is_idr;
	stream_byte_t       awaited_bytes[$];
	int                 mismatches = 0;

	assign failures = mismatches;

	task automatic report_mismatch(input string what);
		$display("%0t: mismatch, %s", $time, what);
		mismatches++;
	endtask

	// bytes that one accepted input byte puts on the stream
	task automatic packetize_byte(input logic [7:0] data, input logic start,
			input logic [FRAME_W-1:0] fbytes, input logic idr, input logic [63:0] ftime);
		logic [FRAME_W-1:0] len;
		logic [SEG_W-1:0]   lim;
		logic [SEG_W-1:0]   seg;
		logic               last;
		logic [1:0]         kind;
		logic [63:0]        diff;
		logic [15:0]        igap;
		logic [15:0]        fgap;
		logic [HDR_W-1:0]   hdr;
		int                 i;
		if (start) begin
			len = (fbytes == '0) ? 21'd1 : fbytes;
			if (len > MAX_FRAME_BYTES)
				len = MAX_FRAME_BYTES;
			// the very first frame measures its gap against itself
			prev_time = seen_frame ? cur_time : ftime;
			cur_time = ftime;
			seen_frame = 1'b1;
			frame_is_idr = idr;
			if (idr) begin
				idr_time = ftime;
				seen_idr = 1'b1;
			end
			frame_left = len;
			seg_left = '0;
			seg_count = '0;
		end
		if (frame_left == '0)
			return;
		if (seg_left == '0) begin
			lim = cfg.max_segment;
			if (lim == '0)
				lim = 10'd1;
			if (lim > SEGMENT_CAP)
				lim = SEGMENT_CAP;
			seg = (frame_left < FRAME_W'(lim)) ? frame_left[SEG_W-1:0] : lim;
			last = (frame_left <= FRAME_W'(seg));
			if (seg_count == '0)
				kind = KIND_FIRST;
			else if (last)
				kind = KIND_LAST;
			else
				kind = KIND_MIDDLE;
			diff = cur_time - idr_time;
			igap = seen_idr ? diff[15:0] : 16'd0;
			diff = cur_time - prev_time;
			fgap = diff[15:0];
			hdr = {MAGIC_WORD, VERSION_BYTE, last, cfg.payload_type, seq_num, cfg.sim_bcd,
				cfg.logical_channel, 3'b000, ~frame_is_idr, 2'b00, kind, cur_time, igap, fgap,
				6'b000000, seg};
			for (i = HEADER_BYTES - 1; i >= 0; i--)
				awaited_bytes.push_back({hdr[i*8 +: 8], 2'b00});
			seq_num = seq_num + 16'd1;
			// saturating, so a long frame never sees a second first segment
			if (seg_count != 11'h7FF)
				seg_count = seg_count + 11'd1;
			seg_left = seg;
		end
		seg_left = seg_left - 10'd1;
		frame_left = frame_left - 21'd1;
		awaited_bytes.push_back({data, seg_left == '0, 1'b1});
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		stream_byte_t want;
		if (!arst_n) begin
			cfg = {SIM_RESET, CHAN_RESET, PTYPE_RESET, MAXSEG_RESET};
			seq_num = '0;
			frame_left = '0;
			seg_left = '0;
			seg_count = '0;
			cur_time = '0;
			prev_time = '0;
			idr_time = '0;
			seen_frame = 1'b0;
			seen_idr = 1'b0;
			frame_is_idr = 1'b0;
			awaited_bytes.delete();
			outstanding <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (reg_index_t'(cfg_index))
					REG_SIM_BCD:      cfg.sim_bcd = cfg_data;
					REG_CHANNEL:      cfg.logical_channel = cfg_data[7:0];
					REG_PAYLOAD_TYPE: cfg.payload_type = cfg_data[6:0];
					REG_MAX_SEGMENT:  cfg.max_segment = cfg_data[SEG_W-1:0];
					default: begin
					end
				endcase
			end
			if (pop && !empty) begin
				if (awaited_bytes.size() == 0) begin
					report_mismatch($sformatf("unexpected item, out_byte %h", out_byte));
				end else begin
					want = awaited_bytes.pop_front();
					if (out_byte !== want.value)
						report_mismatch($sformatf("out_byte %h, want %h", out_byte, want.value));
					if (packet_end !== want.packet_last)
						report_mismatch($sformatf("packet_end %b, want %b", packet_end,
							want.packet_last));
					if (run_end !== want.item_last)
						report_mismatch($sformatf("run_end %b, want %b", run_end, want.item_last));
				end
			end
			if (push && !full)
				packetize_byte(data_byte, frame_start, frame_bytes, is_idr, frame_time_ms);
			outstanding <= awaited_bytes.size();
		end
	end

endmodule

### test/tb_video_frame_rtp_packetizer.sv
// testbench top of the video frame packetizer: stimulus, idling on both sides and verdict
module tb_video_frame_rtp_packetizer;
	import vfrp_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [7:0]         data_byte;
	logic               frame_start;
	logic [FRAME_W-1:0] frame_bytes;
	logic               is_idr;
	logic [63:0]        frame_time_ms;
	logic               empty;
	logic               pop;
	logic [7:0]         out_byte;
	logic               packet_end;
	logic               run_end;
	logic               cfg_wr_en;
	logic [1:0]         cfg_index;
	logic [47:0]        cfg_data;

	// from the checker: mismatches so far and output bytes still awaited
	int                 failures;
	int                 outstanding;

	// sender adds random idle gaps only while not calm
	bit                 tx_calm = 1'b0;
	int                 items_sent;
	logic [63:0]        t_now;

	video_frame_rtp_packetizer i_dut (.*);

	packet_stream_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// worst case is far below this: every item at 31 bytes, each byte behind the longest stall
	initial begin
		#60000000;
		$display("CHECKS FAILED");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 80);
	endfunction

	// offer one item and hold it until the block takes it, then maybe idle a while
	task automatic send_item(input logic [7:0] d, input logic s, input logic [FRAME_W-1:0] fb,
			input logic idr, input logic [63:0] ft);
		int gap;
		push <= 1'b1;
		data_byte <= d;
		frame_start <= s;
		frame_bytes <= fb;
		is_idr <= idr;
		frame_time_ms <= ft;
		@(posedge clk);
		while (full)
			@(posedge clk);
		// push stays high when no gap follows, so the next item goes back to back
		if (!tx_calm && $urandom_range(0, 99) < 30) begin
			gap = pick_gap();
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending and wait until every predicted byte has left the block
	task automatic drain_results();
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// frame header fields on the first byte, junk in them on the rest (the block ignores it)
	task automatic send_frame(input logic [FRAME_W-1:0] declared, input int n_bytes,
			input logic idr, input logic [63:0] ft, input bit may_drain);
		int i;
		send_item(8'($urandom_range(0, 255)), 1'b1, declared, idr, ft);
		for (i = 1; i < n_bytes; i++) begin
			// now and then the sender holds off mid-frame until the stream has fully drained
			if (may_drain && $urandom_range(0, 149) == 0)
				drain_results();
			send_item(8'($urandom_range(0, 255)), 1'b0, FRAME_W'($urandom),
				1'($urandom_range(0, 1)), {$urandom, $urandom});
		end
		items_sent += n_bytes;
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [47:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// registers only change on an idle block
	task automatic set_config(input logic [47:0] sim, input logic [7:0] chan,
			input logic [6:0] ptype, input logic [SEG_W-1:0] maxseg);
		drain_results();
		repeat (40) @(posedge clk);
		write_reg(REG_SIM_BCD, sim);
		write_reg(REG_CHANNEL, chan);
		write_reg(REG_PAYLOAD_TYPE, ptype);
		write_reg(REG_MAX_SEGMENT, maxseg);
	endtask

	// receiver: random stalls, with calm stretches where it takes every byte
	initial begin : pop_side
		int stall;
		int stretch;
		bit calm;
		pop <= 1'b0;
		stall = 0;
		stretch = 0;
		calm = 1'b0;
		forever begin
			@(posedge clk);
			if (stretch == 0) begin
				calm = ($urandom_range(0, 3) == 0);
				stretch = $urandom_range(100, 400);
			end else begin
				stretch--;
			end
			if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
				if (!calm && $urandom_range(0, 99) < 30)
					stall = pick_gap();
			end
		end
	end

	initial begin : stimulus
		int r;
		int n;
		int len;
		int frames_since_cfg;
		bit frame_open;
		logic idr;
		logic [FRAME_W-1:0] declared;
		logic [47:0] sim;
		logic [SEG_W-1:0] maxseg;

		// every input known from the start
		arst_n <= 1'b0;
		push <= 1'b0;
		data_byte <= '0;
		frame_start <= 1'b0;
		frame_bytes <= '0;
		is_idr <= 1'b0;
		frame_time_ms <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_SIM_BCD;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset settings first
		// lone byte before any frame: ignored
		send_item(8'h5a, 1'b0, '0, 1'b0, '0);
		// first frame: zero length taken as one byte, frame gap zero, no idr yet
		send_frame(21'd0, 1, 1'b0, 64'd0, 1'b0);
		// idr frame at the latest possible time, extreme data bytes
		send_item(8'hff, 1'b1, 21'd3, 1'b1, '1);
		send_item(8'h00, 1'b0, '1, 1'b0, '0);
		send_item(8'h80, 1'b0, '0, 1'b1, '1);
		// byte past the end of a frame: ignored
		send_item(8'h33, 1'b0, 21'd5, 1'b1, 64'd7);
		// oversized length is saturated, then a new frame cuts it short
		send_frame('1, 2, 1'b0, 64'h0000_0000_0001_2345, 1'b0);
		send_frame(21'd2, 2, 1'b0, 64'h0000_0000_0001_236d, 1'b0);
		// maximum segment of zero behaves as one: one-byte packets
		set_config('1, 8'hff, 7'h7f, 10'd0);
		send_frame(21'd2, 2, 1'b1, 64'h0000_0000_0001_2400, 1'b0);
		// first, middle and last segments
		set_config('0, 8'h00, 7'h00, 10'd2);
		send_frame(21'd5, 5, 1'b0, 64'h0000_0000_0001_2420, 1'b0);
		// segment size above the cap is clipped
		set_config(48'h999999999999, 8'd7, PTYPE_RESET, 10'h3ff);
		send_frame(21'd3, 3, 1'b1, 64'h8000_0000_0000_0000, 1'b0);
		t_now = 64'h8000_0000_0000_0021;

		// random part: mostly whole frames, some cut short, some stray bytes
		items_sent = 0;
		frame_open = 1'b0;
		frames_since_cfg = 0;
		while (items_sent < 370) begin
			if (!frame_open && frames_since_cfg >= 5 && $urandom_range(0, 2) == 0) begin
				r = $urandom_range(0, 99);
				if (r < 15)
					maxseg = 10'd0;
				else if (r < 30)
					maxseg = 10'd1;
				else if (r < 45)
					maxseg = SEG_W'($urandom_range(2, 4));
				else if (r < 75)
					maxseg = SEG_W'($urandom_range(5, 16));
				else if (r < 85)
					maxseg = SEGMENT_CAP;
				else if (r < 92)
					maxseg = 10'h3ff;
				else
					maxseg = SEG_W'($urandom_range(0, 1023));
				case ($urandom_range(0, 3))
					0:       sim = '0;
					1:       sim = '1;
					default: sim = 48'({$urandom, $urandom});
				endcase
				set_config(sim, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)), maxseg);
				frames_since_cfg = 0;
			end
			tx_calm = ($urandom_range(0, 4) == 0);
			// time mostly moves forward a little, sometimes jumps or steps back
			r = $urandom_range(0, 99);
			if (r < 80)
				t_now = t_now + 64'($urandom_range(0, 120));
			else if (r < 90)
				t_now = {$urandom, $urandom};
			else
				t_now = t_now - 64'($urandom_range(1, 500));
			idr = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 10 && !frame_open) begin
				// stray bytes between frames, not counted
				repeat ($urandom_range(1, 4))
					send_item(8'($urandom_range(0, 255)), 1'b0, FRAME_W'($urandom),
						1'($urandom_range(0, 1)), {$urandom, $urandom});
			end else if (r < 25) begin
				// frame left unfinished, the next frame start drops the rest
				declared = $urandom_range(0, 1) ? FRAME_W'($urandom) :
					FRAME_W'($urandom_range(2, 16));
				n = $urandom_range(1, 6);
				if (declared <= 1)
					n = 1;
				else if (n >= int'(declared))
					n = int'(declared) - 1;
				send_frame(declared, n, idr, t_now, 1'b0);
				frame_open = (int'(declared) > n);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60)
					len = $urandom_range(1, 6);
				else if (r < 90)
					len = $urandom_range(7, 20);
				else
					len = $urandom_range(21, 48);
				declared = (len == 1 && $urandom_range(0, 1) == 1) ? 21'd0 : FRAME_W'(len);
				send_frame(declared, len, idr, t_now, 1'b1);
				frame_open = 1'b0;
			end
			frames_since_cfg++;
		end

		// let the stream drain, then watch a while for anything unexpected
		drain_results();
		repeat (60) @(posedge clk);
		if (failures == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
